### rtl/core/first_token_per_line_extractor_unit_assert.svh
// Assertion macros for the first-token-per-line extractor checker.
// Included by ftpl_checker.sv; no other dependencies.
`ifndef FIRST_TOKEN_PER_LINE_EXTRACTOR_UNIT_ASSERT_SVH
`define FIRST_TOKEN_PER_LINE_EXTRACTOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define FTPL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define FTPL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ftpl_pkg.sv
// Shared types and constants for the first-token-per-line extractor.
// No dependencies; imported by the cell, control and top-level modules.
package ftpl_pkg;

    localparam int MAX_WORD   = 64;
    localparam int NUM_CELLS  = MAX_WORD - 1;
    localparam int LEN_W      = $clog2(MAX_WORD);
    localparam int WS_W       = 7;
    localparam int CHAR_W     = 8;
    localparam int IDX_W      = 16;

    localparam logic [CHAR_W-1:0] HASH_CODE     = 8'h23;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE  = 8'h0A;
    localparam logic [CHAR_W-1:0] PRINT_LO      = 8'h21;
    localparam logic [CHAR_W-1:0] PRINT_HI      = 8'h7E;
    localparam logic [WS_W-1:0]   WS_RESET      = 7'd32;
    localparam logic [WS_W-1:0]   WS_MIN        = 7'd1;
    localparam logic [WS_W-1:0]   WS_MAX        = 7'(MAX_WORD);

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } ftpl_state_t;

    // Control word from the sequencer to the cell chain
    typedef struct packed {
        logic              shift;
        logic              load;
        logic [LEN_W-1:0]  wr_idx;
        logic [CHAR_W-1:0] wr_data;
    } chain_ctrl_t;

endpackage

### rtl/core/first_token_per_line_extractor_unit.sv
// A byte is taken per cycle while collecting; a token of n characters leaves the
// cell chain after its ending byte, one word per cycle unless out_stall holds it.
// Input is stalled while the token drains through the single head cell that
// feeds the output register. Output register decouples result and input.
// Reset (rst_n, async low) returns to line start with word_size 32; no clearing pass.
// Top level: instantiates ftpl_ctrl and a chain of ftpl_cell; uses ftpl_pkg.
module first_token_per_line_extractor_unit
    import ftpl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [WS_W-1:0]   cfg_word_size,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              end_of_input,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CHAR_W-1:0] word_char,
    output logic [LEN_W-1:0]  char_position,
    output logic [IDX_W-1:0]  word_index,
    output logic              last_char
);

    chain_ctrl_t       chain;
    logic [CHAR_W-1:0] cell_data [NUM_CELLS];

    assign cfg_ready = 1'b1;

    ftpl_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_word_size (cfg_word_size),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .char_code     (char_code),
        .end_of_input  (end_of_input),
        .head_data     (cell_data[0]),
        .chain         (chain),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .word_char     (word_char),
        .char_position (char_position),
        .word_index    (word_index),
        .last_char     (last_char)
    );

    // Build the chain; each cell hands its byte to the one below on a shift
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        logic [CHAR_W-1:0] nbr;
        logic              load_en;

        if (i == NUM_CELLS - 1)
        begin : g_tail
            assign nbr = '0;
        end
        else
        begin : g_body
            assign nbr = cell_data[i+1];
        end

        assign load_en = chain.load && (chain.wr_idx == LEN_W'(i));

        ftpl_cell u_cell (
            .clk      (clk),
            .ctrl     (chain),
            .load_en  (load_en),
            .shift_in (nbr),
            .data     (cell_data[i])
        );
    end

endmodule

### rtl/core/ftpl_cell.sv
// One character cell of the token chain: loads a byte at its slot or
// takes its neighbor's byte on a shift. Depends on ftpl_pkg.
module ftpl_cell
    import ftpl_pkg::*;
(
    input  logic              clk,
    input  chain_ctrl_t       ctrl,
    input  logic              load_en,
    input  logic [CHAR_W-1:0] shift_in,
    output logic [CHAR_W-1:0] data
);

    logic [CHAR_W-1:0] data_reg;
    logic [CHAR_W-1:0] data_next;

    // Shift toward the head while emitting, else capture a new byte when load_en
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift)
        begin
            data_next = shift_in;
        end
        else if (load_en)
        begin
            data_next = ctrl.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### rtl/core/ftpl_ctrl.sv
// Line parser and emit sequencer for the first-token-per-line extractor.
// Depends on ftpl_pkg; drives the cell chain through chain_ctrl_t.
module ftpl_ctrl
    import ftpl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [WS_W-1:0]   cfg_word_size,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              end_of_input,
    input  logic [CHAR_W-1:0] head_data,
    output chain_ctrl_t       chain,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CHAR_W-1:0] word_char,
    output logic [LEN_W-1:0]  char_position,
    output logic [IDX_W-1:0]  word_index,
    output logic              last_char
);

    ftpl_state_t       state_reg, state_next;
    logic [WS_W-1:0]   ws_reg, ws_next;
    logic              line_start_reg, line_start_next;
    logic              skip_reg, skip_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [IDX_W-1:0]  count_reg, count_next;
    logic [LEN_W-1:0]  emit_n_reg, emit_n_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic              ov_reg, ov_next;
    logic [CHAR_W-1:0] oc_reg, oc_next;
    logic [LEN_W-1:0]  op_reg, op_next;
    logic [IDX_W-1:0]  oi_reg, oi_next;
    logic              ol_reg, ol_next;

    logic              accept;
    logic              is_print;
    logic              is_nl;
    logic [WS_W-1:0]   slot;
    logic              fits;
    logic              out_free;
    logic              emit_last;

    assign accept    = in_valid && !in_stall;
    assign is_print  = (char_code >= PRINT_LO) && (char_code <= PRINT_HI);
    assign is_nl     = (char_code == NEWLINE_CODE);
    assign out_free  = !ov_reg || !out_stall;
    assign emit_last = (pos_reg == emit_n_reg - LEN_W'(1));

    // Clamp the word size to the supported range
    always_comb
    begin
        slot = ws_reg;
        if (ws_reg < WS_MIN)
        begin
            slot = WS_MIN;
        end
        else if (ws_reg > WS_MAX)
        begin
            slot = WS_MAX;
        end
    end

    assign fits = ({1'b0, len_reg} + WS_W'(1)) < slot;

    // Next state: parse one byte while collecting, drain chain while emitting
    always_comb
    begin
        state_next      = state_reg;
        ws_next         = cfg_valid ? cfg_word_size : ws_reg;
        line_start_next = line_start_reg;
        skip_next       = skip_reg;
        len_next        = len_reg;
        count_next      = count_reg;
        emit_n_next     = emit_n_reg;
        pos_next        = pos_reg;
        ov_next         = ov_reg;
        oc_next         = oc_reg;
        op_next         = op_reg;
        oi_next         = oi_reg;
        ol_next         = ol_reg;
        chain.shift     = 1'b0;
        chain.load      = 1'b0;
        chain.wr_idx    = len_reg;
        chain.wr_data   = char_code;

        // Drop the output word once taken
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_COLLECT:
            begin
                if (accept)
                begin
                    if (end_of_input)
                    begin
                        line_start_next = 1'b1;
                        skip_next       = 1'b0;
                        len_next        = '0;
                        count_next      = '0;
                    end
                    else if (skip_reg)
                    begin
                        if (is_nl)
                        begin
                            skip_next       = 1'b0;
                            line_start_next = 1'b1;
                        end
                    end
                    else if (line_start_reg && char_code == HASH_CODE)
                    begin
                        line_start_next = 1'b0;
                        skip_next       = 1'b1;
                    end
                    else if (!is_print && len_reg == '0)
                    begin
                        line_start_next = is_nl;
                    end
                    else if (is_print && fits)
                    begin
                        line_start_next = 1'b0;
                        chain.load      = 1'b1;
                        len_next        = len_reg + LEN_W'(1);
                    end
                    else
                    begin
                        // Token ends: newline returns to line start, else drop the rest
                        line_start_next = is_nl;
                        skip_next       = !is_nl;
                        len_next        = '0;
                        if (len_reg != '0)
                        begin
                            emit_n_next = len_reg;
                            pos_next    = '0;
                            state_next  = ST_EMIT;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    chain.shift = 1'b1;
                    ov_next     = 1'b1;
                    oc_next     = head_data;
                    op_next     = pos_reg;
                    oi_next     = count_reg;
                    ol_next     = emit_last;
                    pos_next    = pos_reg + LEN_W'(1);
                    if (emit_last)
                    begin
                        count_next = count_reg + IDX_W'(1);
                        state_next = ST_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_COLLECT;
            ws_reg         <= WS_RESET;
            line_start_reg <= 1'b1;
            skip_reg       <= 1'b0;
            len_reg        <= '0;
            count_reg      <= '0;
            emit_n_reg     <= '0;
            pos_reg        <= '0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ws_reg         <= ws_next;
            line_start_reg <= line_start_next;
            skip_reg       <= skip_next;
            len_reg        <= len_next;
            count_reg      <= count_next;
            emit_n_reg     <= emit_n_next;
            pos_reg        <= pos_next;
            ov_reg         <= ov_next;
        end
    end

    // Output payload holds while stalled
    always_ff @(posedge clk)
    begin
        oc_reg <= oc_next;
        op_reg <= op_next;
        oi_reg <= oi_next;
        ol_reg <= ol_next;
    end

    assign in_stall      = (state_reg != ST_COLLECT);
    assign out_valid     = ov_reg;
    assign word_char     = oc_reg;
    assign char_position = op_reg;
    assign word_index    = oi_reg;
    assign last_char     = ol_reg;

endmodule

### rtl/core/ftpl_checker.sv
// Port-level checker for the first-token-per-line extractor, with its bind.
// Depends on ftpl_pkg and first_token_per_line_extractor_unit_assert.svh.
`include "first_token_per_line_extractor_unit_assert.svh"

module ftpl_checker
    import ftpl_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic [WS_W-1:0]   cfg_word_size,
    input logic              in_valid,
    input logic              in_stall,
    input logic [CHAR_W-1:0] char_code,
    input logic              end_of_input,
    input logic              out_valid,
    input logic              out_stall,
    input logic [CHAR_W-1:0] word_char,
    input logic [LEN_W-1:0]  char_position,
    input logic [IDX_W-1:0]  word_index,
    input logic              last_char
);

    // Hold a stalled output word
    `FTPL_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "output word dropped while stalled")

    // Advance position within one token without gaps
    `FTPL_ASSERT_NXT(a_pos_step, clk, rst_n, out_valid && !out_stall && !last_char, out_valid && char_position == $past(char_position) + 6'd1 && word_index == $past(word_index), "token characters not contiguous")

    // Stall input while a token is still draining
    `FTPL_ASSERT_IMP(a_in_held, clk, rst_n, out_valid && !last_char, in_stall, "input taken during token emission")

    // Close the token after its last character
    `FTPL_ASSERT_NXT(a_tok_end, clk, rst_n, out_valid && !out_stall && last_char, !out_valid, "word after last character of token")

endmodule

bind first_token_per_line_extractor_unit ftpl_checker u_ftpl_checker (.*);

### tb/tb_first_token_per_line_extractor_unit.sv
// Testbench for first_token_per_line_extractor_unit: streams text bytes, predicts
// the first token of every line and checks each emitted character in order.
// Depends on ftpl_pkg and the RTL of the extractor only.
module tb_first_token_per_line_extractor_unit;
    import ftpl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          HALF_PERIOD  = 6;
    localparam int          RESET_CYCLES = 9;
    localparam int          SETTLE       = 8;
    localparam int          MAX_GAP      = 10;
    localparam int          PHASE_BYTES  = 12;
    localparam int          CYCLE_LIMIT  = 2000000;
    localparam logic [7:0]  SPACE_CODE   = 8'h20;
    localparam logic [7:0]  TAB_CODE     = 8'h09;
    localparam logic [7:0]  DEL_CODE     = 8'h7F;
    localparam logic [7:0]  VTAB_CODE    = 8'h0B;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [LEN_W-1:0]  pos;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } token_char_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [WS_W-1:0]   cfg_word_size;
    logic              in_valid;
    logic              in_stall;
    logic [CHAR_W-1:0] char_code;
    logic              end_of_input;
    logic              out_valid;
    logic              out_stall;
    logic [CHAR_W-1:0] word_char;
    logic [LEN_W-1:0]  char_position;
    logic [IDX_W-1:0]  word_index;
    logic              last_char;

    // Expected token characters, oldest first
    token_char_t expected_chars[$];
    token_char_t head_char;

    // Shadow of the extractor state
    logic [WS_W-1:0]   shadow_word_size;
    bit                line_start;
    bit                skip_line;
    logic [CHAR_W-1:0] token_buf [NUM_CELLS];
    int                token_len;
    logic [IDX_W-1:0]  token_cnt;

    bit calm;
    int errors;
    int bytes_sent;
    int tokens_predicted;
    int chars_checked;
    int sizes_written;
    int cycle_count;

    first_token_per_line_extractor_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_word_size (cfg_word_size),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .char_code     (char_code),
        .end_of_input  (end_of_input),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .word_char     (word_char),
        .char_position (char_position),
        .word_index    (word_index),
        .last_char     (last_char)
    );

    // Free-running clock
    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Count cycles for the watchdog
    initial cycle_count = 0;
    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    function automatic bit is_printable(input logic [CHAR_W-1:0] c);
        return c >= PRINT_LO && c <= PRINT_HI;
    endfunction

    // Clamp the register into the usable slot range
    function automatic int slot_size(input logic [WS_W-1:0] ws);
        int s;
        s = ws;
        if (s < 1)
            s = 1;
        if (s > MAX_WORD)
            s = MAX_WORD;
        return s;
    endfunction

    task automatic clear_stream();
        line_start = 1'b1;
        skip_line  = 1'b0;
        token_len  = 0;
        token_cnt  = '0;
    endtask

    // Advance the shadow state by one accepted byte; queue any emitted token
    task automatic predict_byte(input logic [CHAR_W-1:0] c, input logic eoi);
        int          slot;
        int          k;
        token_char_t e;
        if (eoi)
        begin
            clear_stream();
            return;
        end
        slot = slot_size(shadow_word_size);
        if (skip_line)
        begin
            if (c == NEWLINE_CODE)
            begin
                skip_line  = 1'b0;
                line_start = 1'b1;
            end
            return;
        end
        if (line_start && c == HASH_CODE)
        begin
            line_start = 1'b0;
            skip_line  = 1'b1;
            return;
        end
        line_start = 1'b0;
        if (!is_printable(c) && token_len == 0)
        begin
            if (c == NEWLINE_CODE)
                line_start = 1'b1;
            return;
        end
        if (is_printable(c) && token_len + 1 < slot)
        begin
            token_buf[token_len] = c;
            token_len++;
            return;
        end
        // Token ends on this byte
        if (c == NEWLINE_CODE)
            line_start = 1'b1;
        else
            skip_line = 1'b1;
        if (token_len == 0)
            return;
        for (k = 0; k < token_len; k++)
        begin
            e.ch   = token_buf[k];
            e.pos  = LEN_W'(k);
            e.idx  = token_cnt;
            e.last = (k + 1 == token_len);
            expected_chars.push_back(e);
        end
        token_len = 0;
        token_cnt = token_cnt + 1'b1;
        tokens_predicted++;
    endtask

    // Send one input word after a random gap, none when calm, and predict on acceptance
    task automatic push_byte(input logic [CHAR_W-1:0] c, input logic eoi = 1'b0);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        char_code    <= c;
        end_of_input <= eoi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_byte(c, eoi);
        bytes_sent++;
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    // Hold the input idle until every expected character is out
    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
    endtask

    task automatic write_word_size(input logic [WS_W-1:0] ws);
        @(negedge clk);
        cfg_valid     <= 1'b1;
        cfg_word_size <= ws;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_word_size = ws;
        sizes_written++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] random_blank();
        case ($urandom_range(0, 4))
            0: return SPACE_CODE;
            1: return TAB_CODE;
            2: return 8'h00;
            3: return DEL_CODE;
            default: return 8'($urandom_range(8'h80, 8'hFF));
        endcase
    endfunction

    function automatic logic [7:0] random_non_newline();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == NEWLINE_CODE)
            c = VTAB_CODE;
        return c;
    endfunction

    // One random line: mostly well-formed, some comments, noise and end of input
    task automatic random_line(input int slot);
        int kind;
        int len;
        int k;
        kind = $urandom_range(0, 11);
        if (kind == 0)
        begin
            push_byte(HASH_CODE);
            repeat ($urandom_range(0, 4))
                push_byte(random_non_newline());
            push_byte(NEWLINE_CODE);
        end
        else if (kind == 1)
        begin
            repeat ($urandom_range(1, 5))
                push_byte(8'($urandom_range(0, 255)));
        end
        else if (kind == 2)
            push_byte(8'($urandom_range(0, 255)), 1'b1);
        else
        begin
            repeat ($urandom_range(0, 2))
                push_byte(random_blank());
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(1, slot + 1);
            else
                len = $urandom_range(1, (slot < 8) ? slot : 8);
            for (k = 0; k < len; k++)
                push_byte(8'($urandom_range(PRINT_LO, PRINT_HI)));
            if ($urandom_range(0, 1) == 0)
                push_byte(NEWLINE_CODE);
            else
            begin
                push_byte(random_blank());
                repeat ($urandom_range(0, 3))
                    push_byte(random_non_newline());
                push_byte(NEWLINE_CODE);
            end
        end
    endtask

    task automatic random_phase(input logic [WS_W-1:0] ws);
        int stop_at;
        drain_block();
        write_word_size(ws);
        stop_at = bytes_sent + PHASE_BYTES;
        while (bytes_sent < stop_at)
            random_line(slot_size(ws));
    endtask

    // Plain lines, comments, blank newline, leading junk, dropped tail, end of input
    task automatic test_directed_lines();
        drain_block();
        write_word_size(WS_RESET);
        push_text("ab\n");
        push_text("#z\n");
        push_text("\n#q\n");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(SPACE_CODE);
        push_text("!~");
        push_byte(DEL_CODE);
        push_text("x\n");
        push_byte("k");
        push_byte(8'hFF, 1'b1);
        push_text("m\n");
    endtask

    // Shrink the slot under a pending token; it must come out whole
    task automatic test_resize_mid_token();
        drain_block();
        write_word_size(7'd32);
        push_text("abcdefghij");
        drain_block();
        write_word_size(7'd4);
        push_text("kz\n");
    endtask

    // Full-length token and one byte past it at the largest slot
    task automatic test_longest_token();
        int k;
        drain_block();
        write_word_size(WS_MAX);
        for (k = 0; k < NUM_CELLS; k++)
            push_byte(8'($urandom_range(PRINT_LO, PRINT_HI)));
        push_byte(NEWLINE_CODE);
        for (k = 0; k < MAX_WORD; k++)
            push_byte(8'($urandom_range(PRINT_LO, PRINT_HI)));
        push_byte(NEWLINE_CODE);
    endtask

    // Random traffic over a sweep of slot sizes, extremes and out-of-range values
    task automatic test_size_sweep();
        random_phase(7'd1);
        random_phase(7'd0);
        random_phase(7'd2);
        random_phase(7'd64);
        random_phase(7'd127);
        random_phase(7'd65);
        random_phase(7'd3);
        random_phase(7'd63);
        random_phase(7'd32);
        random_phase(7'($urandom_range(0, 127)));
        random_phase(7'($urandom_range(2, 12)));
    endtask

    // No gaps on either side
    task automatic test_back_to_back();
        calm = 1'b1;
        random_phase(7'd16);
        random_phase(7'd5);
        calm = 1'b0;
    endtask

    // Randomly stall the result side before each word, except when calm
    initial
    begin : stall_gen
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = calm ? 0 : $urandom_range(0, MAX_GAP);
            repeat (n)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Compare every accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("unexpected word: word_char %h char_position %0d word_index %0d",
                       word_char, char_position, word_index);
                errors++;
            end
            else
            begin
                head_char = expected_chars.pop_front();
                chars_checked++;
                if (word_char !== head_char.ch)
                begin
                    $error("word_char: expected %h, got %h", head_char.ch, word_char);
                    errors++;
                end
                if (char_position !== head_char.pos)
                begin
                    $error("char_position: expected %0d, got %0d", head_char.pos,
                           char_position);
                    errors++;
                end
                if (word_index !== head_char.idx)
                begin
                    $error("word_index: expected %0d, got %0d", head_char.idx, word_index);
                    errors++;
                end
                if (last_char !== head_char.last)
                begin
                    $error("last_char: expected %0b, got %0b", head_char.last, last_char);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        cfg_valid        = 1'b0;
        cfg_word_size    = '0;
        in_valid         = 1'b0;
        char_code        = '0;
        end_of_input     = 1'b0;
        calm             = 1'b0;
        errors           = 0;
        bytes_sent       = 0;
        tokens_predicted = 0;
        chars_checked    = 0;
        sizes_written    = 0;
        shadow_word_size = WS_RESET;
        clear_stream();
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_lines();
        test_resize_mid_token();
        test_longest_token();
        test_size_sweep();
        test_back_to_back();

        // Wait out the last tokens
        drain_block();
        if (expected_chars.size() != 0)
        begin
            $error("%0d expected characters never arrived", expected_chars.size());
            errors++;
        end
        $display("tb: streamed %0d bytes, %0d tokens predicted, %0d characters checked",
                 bytes_sent, tokens_predicted, chars_checked);
        $display("tb: %0d slot size writes, from 0 and 1 up to 64 and 127", sizes_written);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
